>>> rtl/core/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked property that also holds across reset.
`define ASSERT_CLK_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> rtl/core/shamh_pkg.sv
`default_nettype none

package shamh_pkg;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [31:0] PAD_MARK = 32'h8000_0000;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } shamh_item_t;

  typedef struct packed {
    logic [2:0]  word_index;
    logic [31:0] digest_word;
    logic        last;
  } shamh_digest_t;

  // One queue entry: a full message word, or the end mark with the
  // left-aligned tail bytes that did not fill a word.
  typedef struct packed {
    logic        is_end;
    logic [1:0]  nbytes;
    logic [31:0] word;
  } shamh_entry_t;

  typedef struct packed {
    logic         push;
    shamh_entry_t entry;
  } shamh_q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } shamh_q_stat_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PAD,
    ST_ZERO,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_START,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } shamh_state_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      3'd7: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/shamh_front.sv
`default_nettype none

module shamh_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    item_valid,
  output logic                         item_stall,
  input  wire shamh_pkg::shamh_item_t  item,
  input  wire shamh_pkg::shamh_q_stat_t q_stat,
  output shamh_pkg::shamh_q_wr_t       q_wr
);
  import shamh_pkg::*;

  logic [23:0] acc;
  logic [1:0]  nb;
  logic        accept;

  assign item_stall = q_stat.full;
  assign accept     = item_valid && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      nb <= 2'd0;
    end else if (accept) begin
      if (item.kind == KIND_END) begin
        nb <= 2'd0;
      end else begin
        nb <= nb + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.kind == KIND_BYTE) begin
      acc <= {acc[15:0], item.data_byte};
    end
  end

  // A word goes out on every fourth byte; the end mark carries the tail.
  always_comb begin
    q_wr.push         = accept && (item.kind == KIND_END || nb == 2'd3);
    q_wr.entry.is_end = item.kind;
    q_wr.entry.nbytes = nb;
    if (item.kind == KIND_END) begin
      unique case (nb)
        2'd0: q_wr.entry.word = 32'h0;
        2'd1: q_wr.entry.word = {acc[7:0], 24'h0};
        2'd2: q_wr.entry.word = {acc[15:0], 16'h0};
        2'd3: q_wr.entry.word = {acc[23:0], 8'h0};
      endcase
    end else begin
      q_wr.entry.word = {acc, item.data_byte};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/shamh_queue.sv
`default_nettype none

module shamh_queue (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire shamh_pkg::shamh_q_wr_t   q_wr,
  input  wire logic                     pop,
  output shamh_pkg::shamh_q_stat_t      q_stat,
  output shamh_pkg::shamh_entry_t       rd_entry
);
  import shamh_pkg::*;

  shamh_entry_t     mem [QDepth];
  logic [QAw-1:0]   wr_ptr;
  logic [QAw-1:0]   rd_ptr;
  logic [QAw:0]     count;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (count == (QAw + 1)'(QDepth));
  assign q_stat.empty = (count == '0);
  assign do_push      = q_wr.push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_entry     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= q_wr.entry;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/shamh_core.sv
`default_nettype none

module shamh_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire shamh_pkg::shamh_entry_t  rd_entry,
  input  wire shamh_pkg::shamh_q_stat_t q_stat,
  output logic                          pop,
  output logic                          digest_valid,
  input  wire logic                     digest_stall,
  output shamh_pkg::shamh_digest_t      digest
);
  import shamh_pkg::*;

  shamh_state_t  state;
  shamh_state_t  state_next;

  logic [31:0]   chain [8];
  logic [31:0]   v [8];
  logic [31:0]   sched [16];
  logic [3:0]    wc;
  logic [5:0]    rnd;
  logic [60:0]   byte_count;
  logic          pad;
  logic          fin;
  logic [2:0]    oidx;
  logic          out_valid;
  shamh_digest_t out_data;
  logic [31:0]   part_word;
  logic [1:0]    part_nb;

  logic          shift_en;
  logic          sched_en;
  logic [31:0]   sched_in;
  logic          load_out;
  logic [63:0]   bit_len;
  logic [31:0]   t1;
  logic [31:0]   t2;
  logic [31:0]   w_new;

  assign bit_len = {byte_count, 3'b000};
  assign t1 = v[7] + bsig1(v[4]) + choose(v[4], v[5], v[6]) + round_k(rnd) + sched[0];
  assign t2 = bsig0(v[0]) + majority(v[0], v[1], v[2]);
  assign w_new = ssig1(sched[14]) + sched[9] + ssig0(sched[1]) + sched[0];

  assign digest_valid = out_valid;
  assign digest       = out_data;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (!q_stat.empty) begin
          priority if (rd_entry.is_end) begin
            state_next = ST_PAD;
          end else if (wc == 4'd15) begin
            state_next = ST_START;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_PAD: begin
        state_next = (wc == 4'd15) ? ST_START : ST_ZERO;
      end
      ST_ZERO: begin
        priority if (wc == 4'd14) begin
          state_next = ST_LEN_HI;
        end else if (wc == 4'd15) begin
          state_next = ST_START;
        end else begin
          state_next = ST_ZERO;
        end
      end
      ST_LEN_HI: state_next = ST_LEN_LO;
      ST_LEN_LO: state_next = ST_START;
      ST_START:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (rnd == 6'd63) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        priority if (fin) begin
          state_next = ST_OUT;
        end else if (pad) begin
          state_next = ST_ZERO;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (load_out && oidx == 3'd7) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    shift_en = 1'b0;
    sched_in = 32'h0;
    load_out = 1'b0;
    unique case (state)
      ST_LOAD: begin
        pop      = !q_stat.empty;
        shift_en = !q_stat.empty && !rd_entry.is_end;
        sched_in = rd_entry.word;
      end
      ST_PAD: begin
        shift_en = 1'b1;
        sched_in = part_word | (PAD_MARK >> {part_nb, 3'b000});
      end
      ST_ZERO: begin
        shift_en = (wc != 4'd14);
      end
      ST_LEN_HI: begin
        shift_en = 1'b1;
        sched_in = bit_len[63:32];
      end
      ST_LEN_LO: begin
        shift_en = 1'b1;
        sched_in = bit_len[31:0];
      end
      ST_ROUND: begin
        sched_in = w_new;
      end
      ST_OUT: begin
        load_out = !out_valid || !digest_stall;
      end
      default: begin
      end
    endcase
    sched_en = shift_en || (state == ST_ROUND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      wc         <= 4'd0;
      rnd        <= 6'd0;
      byte_count <= '0;
      pad        <= 1'b0;
      fin        <= 1'b0;
      oidx       <= 3'd0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= init_hash(3'(i));
      end
    end else begin
      state <= state_next;
      if (shift_en) begin
        wc <= wc + 4'd1;
      end
      if (pop && !rd_entry.is_end) begin
        byte_count <= byte_count + 61'd4;
      end
      if (state == ST_PAD) begin
        pad        <= 1'b1;
        byte_count <= byte_count + 61'(part_nb);
      end
      if (state == ST_LEN_LO) begin
        fin <= 1'b1;
      end
      if (state == ST_START) begin
        rnd <= 6'd0;
      end else if (state == ST_ROUND) begin
        rnd <= rnd + 6'd1;
      end
      if (state == ST_UPDATE) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + v[i];
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!digest_stall) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        oidx <= oidx + 3'd1;
        // last word read out: back to the initial chaining value
        if (oidx == 3'd7) begin
          byte_count <= '0;
          pad        <= 1'b0;
          fin        <= 1'b0;
          for (int i = 0; i < 8; i++) begin
            chain[i] <= init_hash(3'(i));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    // schedule window: sched[0] is the word used by the current round
    if (sched_en) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[15] <= sched_in;
    end
    if (pop && rd_entry.is_end) begin
      part_word <= rd_entry.word;
      part_nb   <= rd_entry.nbytes;
    end
    if (state == ST_START) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= chain[i];
      end
    end else if (state == ST_ROUND) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
    end
    if (load_out) begin
      out_data.word_index  <= oidx;
      out_data.digest_word <= chain[oidx];
      out_data.last        <= (oidx == 3'd7);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sha256_message_hasher_top.sv
// SHA-256 hasher over a byte stream.
// item channel: one transaction per message byte (kind 0) or end mark (kind 1).
// digest channel: eight transactions per end mark, word_index 0..7, the
// most significant digest word first, last set on word 7.
// Bytes enter at up to one per cycle, packed four to a word into a four-word
// queue. The engine loads a block one word per cycle while the queue holds
// words, then hashes it (chaining load, 64 rounds at one round per cycle,
// chaining update) without taking words, so only 16 bytes get in meanwhile;
// throughput on a long message is set by the byte-wide input and the rounds
// not overlapping the block load.
// After an accepted end mark the engine adds the pad word, zero words and
// the two length words, hashing one block, or two when padding needs a
// second one; a block still being hashed is finished first.
// The digest words then leave one per cycle unless the receiver stalls.
// A stall on the digest channel holds the current word; the input side keeps
// filling the queue and stalls once it is full.
// Reset (rst, synchronous) loads the standard initial chaining value and
// clears the byte count; the block is ready in the next cycle.
`default_nettype none

module sha256_message_hasher_top (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    item_valid,
  output logic                         item_stall,
  input  wire shamh_pkg::shamh_item_t  item,
  output logic                         digest_valid,
  input  wire logic                    digest_stall,
  output shamh_pkg::shamh_digest_t     digest
);
  import shamh_pkg::*;

  shamh_q_wr_t   q_wr;
  shamh_q_stat_t q_stat;
  shamh_entry_t  rd_entry;
  logic          pop;

  shamh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_stat     (q_stat),
    .q_wr       (q_wr)
  );

  shamh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_wr     (q_wr),
    .pop      (pop),
    .q_stat   (q_stat),
    .rd_entry (rd_entry)
  );

  shamh_core u_core (
    .clk          (clk),
    .rst          (rst),
    .rd_entry     (rd_entry),
    .q_stat       (q_stat),
    .pop          (pop),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

endmodule

`default_nettype wire

>>> rtl/core/shamh_chk.sv
`default_nettype none

`include "assert_macros.svh"

module shamh_chk (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     digest_valid,
  input wire logic                     digest_stall,
  input wire shamh_pkg::shamh_digest_t digest
);

  logic       held;
  logic       fire;
  logic       last;
  logic [2:0] idx;

  assign held = digest_valid && digest_stall;
  assign fire = digest_valid && !digest_stall;
  assign last = digest.last;
  assign idx  = digest.word_index;

  `ASSERT_CLK(a_digest_hold, clk, rst, held |=> digest_valid && $stable(digest))

  `ASSERT_CLK(a_last_on_seven, clk, rst, digest_valid |-> (last == (idx == 3'd7)))

  // words of one digest leave back to back, in order
  `ASSERT_CLK(a_word_order, clk, rst, fire && !last |=> digest_valid && idx == $past(idx) + 3'd1)

  `ASSERT_CLK_NR(a_quiet_after_reset, clk, rst |=> !digest_valid)

endmodule

bind sha256_message_hasher_top shamh_chk u_shamh_chk (
  .clk          (clk),
  .rst          (rst),
  .digest_valid (digest_valid),
  .digest_stall (digest_stall),
  .digest       (digest)
);

`default_nettype wire
